// ----- sv/esq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esq_pkg
// Shared types and constants of the error-scaled size quantizer.
// ----------------------------------------------------------------------------
package esq_pkg;

   localparam int SIZE_W   = 24;  // size and quantized result
   localparam int START_W  = 20;  // first boundary register
   localparam int FOLDS_W  = 4;   // spacing multiplier register
   localparam int BND_W    = 26;  // stored boundary
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   // Register indexes of the write port.
   localparam logic [CSR_IDX_W-1:0] CSR_FOLDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd1;

   // Reset values of the registers.
   localparam logic [FOLDS_W-1:0] FOLDS_RESET = 4'd4;
   localparam logic [START_W-1:0] START_RESET = 20'd500;

   // Step arithmetic: Q = 16*p^2 - LIN_COEF*p + Q_BIAS,
   // step = floor(2*folds*floor(sqrt(Q)*2^16) / (100*2^16)).
   localparam int Q_W       = 64;
   localparam int SQ_W      = 2 * BND_W;        // p*p
   localparam int LIN_W     = BND_W + 17;       // p*100000
   localparam int ROOT_W    = 48;               // root bits produced
   localparam int ROOT_STEPS = 48;              // one result bit per step
   localparam int PROD_W    = ROOT_W + FOLDS_W + 1;
   localparam int FRAC_BITS = 16;
   // A step is only computed from a boundary below 2^24, so Q < 2^52, the
   // root stays below 2^42 and the scaled root without its fraction fits in
   // 31 bits.
   localparam int DVN_W     = 31;
   // Divide by 100 as a multiply by ceil(2^38/100) and a shift by 38. The
   // rounding error stays below one for every dividend under 2^31.
   localparam int RCP_W     = 32;
   localparam int RCP_SHIFT = 38;
   localparam int QPROD_W   = 64;
   localparam logic [Q_W-1:0]    Q_BIAS    = 64'd400000000;
   localparam logic [16:0]       LIN_COEF  = 17'd100000;
   localparam logic [RCP_W-1:0]  RCP_100   = 32'd2748779070;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic              live;  // token present
      logic              done;  // bracket found, prev holds the answer
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] prev;  // last boundary passed
   } tok_type;

   // Newly computed boundary, broadcast to the waiting cell.
   typedef struct packed {
      logic             done;
      logic [BND_W-1:0] value;
   } gen_type;

endpackage

// ----- sv/error_scaled_size_quantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// error_scaled_size_quantizer
// Snaps fragment sizes down onto a ladder of size-dependent bin boundaries.
// ----------------------------------------------------------------------------
// A size at or below start_cfg is returned unchanged through the hold
// register and the output register. Any other size sends a search token
// down a chain of MAX_BOUNDARIES cells, one cell per cycle while no cell
// waits for a boundary, and its result leaves through the same registers.
// The ladder is built lazily: when the token reaches a cell that holds no
// boundary yet, it waits there while a shared step unit computes the next
// boundary through two multiplies, a sum, a 48-step square root, a scale
// multiply and a reciprocal multiply for the divide by the scale constant;
// the first boundary of an empty ladder is start_cfg and needs no arithmetic.
// The chain holds one request at a time, and a finished result sits in the
// output register while the next request is accepted. Writing either
// register empties the ladder.
// ----------------------------------------------------------------------------
module error_scaled_size_quantizer #(
   parameter int MAX_BOUNDARIES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [esq_pkg::SIZE_W-1:0]      req_size_bp,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [esq_pkg::SIZE_W-1:0]      rsp_quantized,
   output logic                            rsp_beyond_table,
   input  logic                            csr_we,
   input  logic [esq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [esq_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_RUN  = 3'b010,
      T_HOLD = 3'b100
   } top_state_type;

   top_state_type                  state_ff, state_in;
   logic [esq_pkg::FOLDS_W-1:0]    folds_ff;
   logic [esq_pkg::START_W-1:0]    start_ff;
   logic                           clear;
   logic                           req_take, rsp_take, rsp_load;

   // Result waiting to move into the output register.
   logic [esq_pkg::SIZE_W-1:0]     hold_q_ff;
   logic                           hold_b_ff;
   logic                           rsp_valid_ff;
   logic [esq_pkg::SIZE_W-1:0]     rsp_q_ff;
   logic                           rsp_b_ff;

   // Ladder generation control.
   logic                           seeded_ff;
   logic                           gen_busy_ff;
   logic                           seed_pulse_ff;
   logic [esq_pkg::BND_W-1:0]      tail_ff;
   logic                           gen_req, step_start, step_done;
   logic [esq_pkg::BND_W-1:0]      step_next;
   esq_pkg::gen_type               gen;

   // Chain.
   esq_pkg::tok_type               inject;
   esq_pkg::tok_type               link [MAX_BOUNDARIES+1];
   logic [MAX_BOUNDARIES-1:0]      wait_vec;
   logic                           passes;

   assign clear     = csr_we;
   assign req_stall = (state_ff != T_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign passes    = {4'b0000, start_ff} >= req_size_bp;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == T_HOLD) && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_quantized    = rsp_q_ff;
   assign rsp_beyond_table = rsp_b_ff;

   // Configuration registers; an unused index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         folds_ff <= esq_pkg::FOLDS_RESET;
         start_ff <= esq_pkg::START_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            esq_pkg::CSR_FOLDS: folds_ff <= csr_wdata[esq_pkg::FOLDS_W-1:0];
            esq_pkg::CSR_START: start_ff <= csr_wdata[esq_pkg::START_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A request that is not passed through enters the first cell as a fresh token.
   always_comb begin
      inject      = '0;
      inject.live = req_take && !passes;
      inject.size = req_size_bp;
   end

   assign link[0] = inject;

   for (genvar k = 0; k < MAX_BOUNDARIES; k++) begin : g_cell
      esq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear   (clear),
         .tok_in  (link[k]),
         .gen     (gen),
         .tok_out (link[k+1]),
         .waiting (wait_vec[k])
      );
   end

   // The waiting cell is always the first empty one, so its predecessor is
   // the most recently produced boundary held in tail_ff. The first boundary
   // of an empty ladder is start_cfg itself and needs no arithmetic.
   assign gen_req    = |wait_vec;
   assign step_start = gen_req && !gen_busy_ff && seeded_ff;

   esq_step u_step (
      .clock (clock),
      .reset (reset),
      .start (step_start),
      .p     (tail_ff),
      .folds (folds_ff),
      .done  (step_done),
      .next  (step_next)
   );

   always_comb begin
      gen.done  = seed_pulse_ff || step_done;
      gen.value = seed_pulse_ff ? esq_pkg::BND_W'(start_ff) : step_next;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         seeded_ff     <= 1'b0;
         gen_busy_ff   <= 1'b0;
         seed_pulse_ff <= 1'b0;
      end else begin
         seed_pulse_ff <= gen_req && !gen_busy_ff && !seeded_ff;
         if (gen.done) begin
            gen_busy_ff <= 1'b0;
         end else if (gen_req && !gen_busy_ff) begin
            gen_busy_ff <= 1'b1;
         end
         if (seed_pulse_ff) begin
            seeded_ff <= 1'b1;
         end
      end
      if (gen.done) begin
         tail_ff <= gen.value;
      end
   end

   // Request sequencing. A token leaving the last cell unanswered means the
   // ladder is full: its prev field is then the last boundary.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (req_take) state_in = passes ? T_HOLD : T_RUN;
         T_RUN:   if (link[MAX_BOUNDARIES].live) state_in = T_HOLD;
         T_HOLD:  if (rsp_load) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take && passes) begin
         hold_q_ff <= req_size_bp;
         hold_b_ff <= 1'b0;
      end else if (state_ff == T_RUN && link[MAX_BOUNDARIES].live) begin
         hold_q_ff <= link[MAX_BOUNDARIES].prev;
         hold_b_ff <= !link[MAX_BOUNDARIES].done;
      end
      if (rsp_load) begin
         rsp_q_ff <= hold_q_ff;
         rsp_b_ff <= hold_b_ff;
      end
   end

   // Only one cell can wait for a boundary at a time.
   a_one_waiter: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wait_vec))
      else $error("more than one cell waiting for a boundary");

   // A new boundary is only ever delivered to a waiting cell.
   a_gen_has_taker: assert property (@(posedge clock) disable iff (reset)
      gen.done |-> gen_req)
      else $error("boundary produced with no waiting cell");

   // Tokens leave the chain only while a request is being searched.
   a_exit_in_run: assert property (@(posedge clock) disable iff (reset)
      link[MAX_BOUNDARIES].live |-> (state_ff == T_RUN))
      else $error("token left the chain outside a search");

   // A register write empties the ladder.
   a_clear_unseeds: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !seeded_ff)
      else $error("ladder still seeded after a register write");

endmodule

// ----- sv/esq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esq_cell
// One boundary slot of the ladder and one stage of the search chain.
// ----------------------------------------------------------------------------
module esq_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  esq_pkg::tok_type tok_in,
   input  esq_pkg::gen_type gen,
   output esq_pkg::tok_type tok_out,
   output logic             waiting
);

   logic [esq_pkg::BND_W-1:0] bnd_ff;
   logic                      vld_ff;
   esq_pkg::tok_type          tok_ff;
   esq_pkg::tok_type          tok_in_d;
   logic                      below;

   assign waiting = tok_ff.live && !tok_ff.done && !vld_ff;
   assign below   = {2'b00, tok_ff.size} < bnd_ff;

   // A live token moves on once the slot holds a boundary or the answer is known.
   always_comb begin
      tok_out      = tok_ff;
      tok_out.live = tok_ff.live && (tok_ff.done || vld_ff);
      if (!tok_ff.done) begin
         if (below) begin
            tok_out.done = 1'b1;
         end else begin
            tok_out.prev = bnd_ff[esq_pkg::SIZE_W-1:0];
         end
      end
   end

   always_comb begin
      if (tok_in.live) begin
         tok_in_d = tok_in;
      end else if (waiting) begin
         tok_in_d = tok_ff;
      end else begin
         tok_in_d      = tok_ff;
         tok_in_d.live = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff      <= 1'b0;
         tok_ff.live <= 1'b0;
      end else begin
         tok_ff <= tok_in_d;
         if (waiting && gen.done) begin
            vld_ff <= 1'b1;
         end
      end
      if (waiting && gen.done) begin
         bnd_ff <= gen.value;
      end
   end

endmodule

// ----- sv/esq_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esq_step
// Computes the boundary that follows p: squares, a bit-pair square root and
// a reciprocal multiply for the divide by the constant scale.
// ----------------------------------------------------------------------------
module esq_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [esq_pkg::BND_W-1:0]   p,
   input  logic [esq_pkg::FOLDS_W-1:0] folds,
   output logic                        done,
   output logic [esq_pkg::BND_W-1:0]   next
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_SUM   = 7'b0000100,
      ST_ROOT  = 7'b0001000,
      ST_SCALE = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } st_type;

   st_type                         state_ff, state_in;
   logic [esq_pkg::BND_W-1:0]      p_ff;
   logic [esq_pkg::SQ_W-1:0]       sq_ff;
   logic [esq_pkg::LIN_W-1:0]      lin_ff;
   logic [esq_pkg::Q_W-1:0]        q_ff;
   logic [esq_pkg::Q_W-1:0]        rem_ff;
   logic [esq_pkg::ROOT_W-1:0]     root_ff;
   logic [esq_pkg::DVN_W-1:0]      dv_ff;
   logic [esq_pkg::BND_W-1:0]      quo_ff;
   logic [5:0]                     cnt_ff;
   logic [esq_pkg::Q_W-1:0]        rem_sh, trial;
   logic [esq_pkg::PROD_W-1:0]     prod;
   logic [esq_pkg::QPROD_W-1:0]    qprod;

   assign rem_sh  = {rem_ff[esq_pkg::Q_W-3:0], q_ff[esq_pkg::Q_W-1 -: 2]};
   assign trial   = {{(esq_pkg::Q_W-esq_pkg::ROOT_W-2){1'b0}}, root_ff, 2'b01};
   assign prod    = esq_pkg::PROD_W'(root_ff) * esq_pkg::PROD_W'({folds, 1'b0});
   assign qprod   = esq_pkg::QPROD_W'(dv_ff) * esq_pkg::QPROD_W'(esq_pkg::RCP_100);

   assign done = (state_ff == ST_DONE);
   assign next = p_ff + quo_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_ROOT;
         ST_ROOT:  if (cnt_ff == 6'(esq_pkg::ROOT_STEPS - 1)) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIV;
         ST_DIV:   state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      case (state_ff)
         ST_IDLE: begin
            p_ff <= p;
         end
         ST_MUL: begin
            sq_ff  <= p_ff * p_ff;
            lin_ff <= esq_pkg::LIN_W'(p_ff) * esq_pkg::LIN_W'(esq_pkg::LIN_COEF);
         end
         ST_SUM: begin
            q_ff    <= esq_pkg::Q_W'({sq_ff, 4'b0000}) + esq_pkg::Q_BIAS
                       - esq_pkg::Q_W'(lin_ff);
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         ST_ROOT: begin
            q_ff   <= {q_ff[esq_pkg::Q_W-3:0], 2'b00};
            cnt_ff <= cnt_ff + 6'd1;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[esq_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[esq_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         ST_SCALE: begin
            dv_ff <= prod[esq_pkg::FRAC_BITS +: esq_pkg::DVN_W];
         end
         ST_DIV: begin
            quo_ff <= qprod[esq_pkg::RCP_SHIFT +: esq_pkg::BND_W];
         end
         default: begin
         end
      endcase
   end

endmodule
